FILE: src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising clock edge outside reset
`define SGDF_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sgdf check failed");

// check that also runs while reset is low
`define SGDF_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("sgdf check failed");

`endif

FILE: src/sgdf_pkg.sv
// shared types and codes of the grid damping filter
package sgdf_pkg;

    localparam logic [1:0] FUNC_WR_CELL = 2'd0;
    localparam logic [1:0] FUNC_WR_SURF = 2'd1;
    localparam logic [1:0] FUNC_RUN     = 2'd2;
    localparam logic [1:0] FUNC_RD_CELL = 2'd3;

    localparam logic [2:0] CFG_AXIS     = 3'd0;
    localparam logic [2:0] CFG_STRENGTH = 3'd1;
    localparam logic [2:0] CFG_PASSES   = 3'd2;
    localparam logic [2:0] CFG_MASK     = 3'd3;
    localparam logic [2:0] CFG_LAYERS   = 3'd4;
    localparam logic [2:0] CFG_ROWS     = 3'd5;
    localparam logic [2:0] CFG_COLS     = 3'd6;

    localparam int VALUE_W = 32;
    localparam int SURF_W  = 4;

    typedef struct packed {
        logic mul_en;
        logic use_a;
        logic use_b;
    } t_smooth_ctl;

endpackage

FILE: src/sgdf_ram.sv
// generic single write port, single read port ram with registered read
module sgdf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: src/sgdf_smooth.sv
// shared 1-2-1 smoothing unit: laplacian, scaled product, rounding, saturation
module sgdf_smooth (
    input  logic                          i_clk,
    input  sgdf_pkg::t_smooth_ctl         i_ctl,
    input  logic [15:0]                   i_strength,
    input  logic signed [31:0]            i_v,
    input  logic signed [31:0]            i_a,
    input  logic signed [31:0]            i_b,
    output logic signed [31:0]            o_s
);
    import sgdf_pkg::*;

    logic signed [31:0] w_a;
    logic signed [31:0] w_b;
    logic signed [33:0] w_lap;
    logic signed [50:0] w_prod;
    logic signed [50:0] r_p;
    logic signed [31:0] r_v;
    logic signed [51:0] w_q;
    logic signed [33:0] w_d;
    logic signed [34:0] w_s;

    assign w_a    = i_ctl.use_a ? i_a : i_v;
    assign w_b    = i_ctl.use_b ? i_b : i_v;
    assign w_lap  = 34'(w_a) + 34'(w_b) - (34'(i_v) <<< 1);
    assign w_prod = w_lap * $signed({1'b0, i_strength});

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_p <= w_prod;
            r_v <= i_v;
        end
    end

    assign w_q = 52'(r_p) + 52'sd131072;
    assign w_d = w_q[51:18];
    assign w_s = 35'(r_v) + 35'(w_d);

    always_comb begin
        if (w_s > 35'sd2147483647) begin
            o_s = 32'sh7fffffff;
        end else if (w_s < -35'sd2147483648) begin
            o_s = 32'sh80000000;
        end else begin
            o_s = w_s[31:0];
        end
    end
endmodule

FILE: src/shapiro_grid_damping_filter.sv
// top level: grid store, surface store, sequencer of the shared smoothing unit
// cell write: taken in idle; cell read: registered grid read, then S_READ registers the
// result once the output is free; run: per pass and enabled direction setup, copy and
// filtering phases per used cell (layers*rows*cols), a disabled direction S_AXIS and
// S_NEXT, completion result from S_DONE; after reset a sweep zeroes all 2**(row bits
// + col bits) surface entries; requests wait, config writes taken; sync active low reset
module shapiro_grid_damping_filter #(
    parameter int MAX_LAYERS = 8,
    parameter int MAX_ROWS   = 16,
    parameter int MAX_COLS   = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_func,
    input  logic [2:0]         i_layer,
    input  logic [3:0]         i_row,
    input  logic [4:0]         i_col,
    input  logic signed [31:0] i_value,
    input  logic signed [4:0]  i_surface_level,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_read_value,
    output logic               o_run_done
);
    import sgdf_pkg::*;

    localparam int LW  = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int AW  = LW + RW + CW;
    localparam int SAW = RW + CW;
    localparam int LMAXV = MAX_LAYERS - 1;
    localparam int RMAXV = MAX_ROWS - 1;
    localparam int CMAXV = MAX_COLS - 1;

    localparam logic [2:0] PH_CENTER = 3'd0;
    localparam logic [2:0] PH_MINUS  = 3'd1;
    localparam logic [2:0] PH_PLUS   = 3'd2;
    localparam logic [2:0] PH_LAST   = 3'd3;
    localparam logic [2:0] PH_MUL    = 3'd4;
    localparam logic [2:0] PH_WRITE  = 3'd5;

    localparam logic [1:0] AX_COL   = 2'd0;
    localparam logic [1:0] AX_ROW   = 2'd1;
    localparam logic [1:0] AX_LAYER = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_READ, S_AXIS, S_COPY, S_COPY_END, S_FILT, S_NEXT, S_DONE
    } t_state;

    t_state r_state;

    logic [2:0]  r_axis_en;
    logic [15:0] r_strength;
    logic [3:0]  r_passes;
    logic        r_mask;
    logic [3:0]  r_layers;
    logic [4:0]  r_rows;
    logic [5:0]  r_cols;

    logic [LW-1:0]  r_l;
    logic [RW-1:0]  r_r;
    logic [CW-1:0]  r_c;
    logic [LW-1:0]  r_q_l;
    logic [SAW-1:0] r_clr;
    logic [2:0]     r_ph;
    logic [1:0]     r_axis;
    logic [3:0]     r_pass;
    logic           r_cp_wv;
    logic [AW-1:0]  r_cp_waddr;
    logic           r_rd_ok;
    logic           r_fc;
    logic           r_fa;
    logic           r_fb;
    logic signed [31:0] r_v;
    logic signed [31:0] r_a;
    logic signed [31:0] r_b;
    logic           r_out_valid;
    logic signed [31:0] r_out_value;
    logic           r_out_done;

    logic [LW-1:0] w_lmax;
    logic [RW-1:0] w_rmax;
    logic [CW-1:0] w_cmax;
    logic          w_last;
    logic          w_in_acc;
    logic          w_cell_ok;
    logic          w_out_free;
    logic [AW-1:0] w_in_addr;
    logic [AW-1:0] w_cur_addr;
    logic [LW-1:0] w_nl;
    logic [RW-1:0] w_nr;
    logic [CW-1:0] w_nc;
    logic          w_fl;

    logic              g_we;
    logic [AW-1:0]     g_waddr;
    logic [31:0]       g_wdata;
    logic              g_re;
    logic [AW-1:0]     g_raddr;
    logic [31:0]       g_rdata;
    logic              s_re;
    logic [31:0]       s_rdata;
    logic              u_we;
    logic [SAW-1:0]    u_waddr;
    logic [SURF_W-1:0] u_wdata;
    logic [SURF_W-1:0] u_rdata;
    t_smooth_ctl       w_ctl;
    logic signed [31:0] w_smooth;

    assign w_lmax = (r_layers == '0) ? '0 :
                    ({28'b0, r_layers} > MAX_LAYERS) ? LW'(LMAXV) : LW'(r_layers - 4'd1);
    assign w_rmax = (r_rows == '0) ? '0 :
                    ({27'b0, r_rows} > MAX_ROWS) ? RW'(RMAXV) : RW'(r_rows - 5'd1);
    assign w_cmax = (r_cols == '0) ? '0 :
                    ({26'b0, r_cols} > MAX_COLS) ? CW'(CMAXV) : CW'(r_cols - 6'd1);

    assign w_last     = (r_l == w_lmax) && (r_r == w_rmax) && (r_c == w_cmax);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_cell_ok  = ({29'b0, i_layer} < MAX_LAYERS) && ({28'b0, i_row} < MAX_ROWS) &&
                        ({27'b0, i_col} < MAX_COLS);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_in_addr  = {LW'(i_layer), RW'(i_row), CW'(i_col)};
    assign w_cur_addr = {r_l, r_r, r_c};

    // neighbor address for the phase
    always_comb begin
        w_nl = r_l;
        w_nr = r_r;
        w_nc = r_c;
        if (r_ph == PH_MINUS) begin
            case (r_axis)
                AX_COL:   w_nc = (r_c == '0) ? w_cmax : r_c - 1'b1;
                AX_ROW:   w_nr = (r_r == '0) ? '0 : r_r - 1'b1;
                AX_LAYER: w_nl = (r_l == '0) ? '0 : r_l - 1'b1;
                default:  w_nc = r_c;
            endcase
        end else if (r_ph == PH_PLUS) begin
            case (r_axis)
                AX_COL:   w_nc = (r_c == w_cmax) ? '0 : r_c + 1'b1;
                AX_ROW:   w_nr = (r_r == w_rmax) ? w_rmax : r_r + 1'b1;
                AX_LAYER: w_nl = (r_l == w_lmax) ? w_lmax : r_l + 1'b1;
                default:  w_nc = r_c;
            endcase
        end
    end

    assign w_fl = !r_mask || (32'(r_q_l) >= 32'(u_rdata));

    // memory port control
    always_comb begin
        g_we    = 1'b0;
        g_waddr = w_in_addr;
        g_wdata = i_value;
        g_re    = 1'b0;
        g_raddr = w_in_addr;
        u_we    = 1'b0;
        u_waddr = {RW'(i_row), CW'(i_col)};
        u_wdata = i_surface_level[4] ? '0 : i_surface_level[3:0];
        s_re    = 1'b0;
        case (r_state)
            S_CLEAR: begin
                u_we    = 1'b1;
                u_waddr = r_clr;
                u_wdata = '0;
            end
            S_IDLE: begin
                g_we = w_in_acc && (i_func == FUNC_WR_CELL) && w_cell_ok;
                g_re = w_in_acc && (i_func == FUNC_RD_CELL);
                u_we = w_in_acc && (i_func == FUNC_WR_SURF) &&
                       ({28'b0, i_row} < MAX_ROWS) && ({27'b0, i_col} < MAX_COLS);
            end
            S_COPY: begin
                g_re    = 1'b1;
                g_raddr = w_cur_addr;
            end
            S_FILT: begin
                s_re    = (r_ph == PH_CENTER) || (r_ph == PH_MINUS) || (r_ph == PH_PLUS);
                g_we    = (r_ph == PH_WRITE) && r_fc;
                g_waddr = w_cur_addr;
                g_wdata = w_smooth;
            end
            default: begin
                g_we = 1'b0;
            end
        endcase
    end

    assign w_ctl.mul_en = (r_state == S_FILT) && (r_ph == PH_MUL);
    assign w_ctl.use_a  = r_fa;
    assign w_ctl.use_b  = r_fb;

    sgdf_ram #(.WIDTH(32), .DEPTH(2 ** AW)) u_grid (
        .i_clk   (i_clk),
        .i_we    (g_we),
        .i_waddr (g_waddr),
        .i_wdata (g_wdata),
        .i_re    (g_re),
        .i_raddr (g_raddr),
        .o_rdata (g_rdata)
    );

    sgdf_ram #(.WIDTH(32), .DEPTH(2 ** AW)) u_snap (
        .i_clk   (i_clk),
        .i_we    (r_cp_wv),
        .i_waddr (r_cp_waddr),
        .i_wdata (g_rdata),
        .i_re    (s_re),
        .i_raddr ({w_nl, w_nr, w_nc}),
        .o_rdata (s_rdata)
    );

    sgdf_ram #(.WIDTH(SURF_W), .DEPTH(2 ** SAW)) u_surf (
        .i_clk   (i_clk),
        .i_we    (u_we),
        .i_waddr (u_waddr),
        .i_wdata (u_wdata),
        .i_re    (s_re),
        .i_raddr ({w_nr, w_nc}),
        .o_rdata (u_rdata)
    );

    sgdf_smooth u_smooth (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl),
        .i_strength (r_strength),
        .i_v        (r_v),
        .i_a        (r_a),
        .i_b        (r_b),
        .o_s        (w_smooth)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_axis_en   <= 3'd7;
            r_strength  <= 16'd32768;
            r_passes    <= 4'd1;
            r_mask      <= 1'b0;
            r_layers    <= 4'd8;
            r_rows      <= 5'd16;
            r_cols      <= 6'd32;
            r_clr       <= '0;
            r_ph        <= PH_CENTER;
            r_axis      <= AX_COL;
            r_pass      <= '0;
            r_cp_wv     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_AXIS:     r_axis_en  <= i_cfg_data[2:0];
                    CFG_STRENGTH: r_strength <= i_cfg_data;
                    CFG_PASSES:   r_passes   <= i_cfg_data[3:0];
                    CFG_MASK:     r_mask     <= i_cfg_data[0];
                    CFG_LAYERS:   r_layers   <= i_cfg_data[3:0];
                    CFG_ROWS:     r_rows     <= i_cfg_data[4:0];
                    CFG_COLS:     r_cols     <= i_cfg_data[5:0];
                    default:      r_mask     <= r_mask;
                endcase
            end

            if (i_out_ready && (r_state != S_READ) && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            r_cp_wv    <= (r_state == S_COPY);
            r_cp_waddr <= w_cur_addr;

            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (&r_clr) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_in_acc) begin
                        case (i_func)
                            FUNC_RD_CELL: begin
                                r_rd_ok <= w_cell_ok;
                                r_state <= S_READ;
                            end
                            FUNC_RUN: begin
                                r_pass  <= '0;
                                r_axis  <= AX_COL;
                                r_state <= (r_passes == '0) ? S_DONE : S_AXIS;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_value <= r_rd_ok ? g_rdata : '0;
                        r_out_done  <= 1'b0;
                        r_state     <= S_IDLE;
                    end else begin
                        r_out_valid <= 1'b1;
                    end
                end
                S_AXIS: begin
                    r_l <= '0;
                    r_r <= '0;
                    r_c <= '0;
                    r_state <= r_axis_en[r_axis] ? S_COPY : S_NEXT;
                end
                S_COPY, S_FILT: begin
                    if ((r_state == S_COPY) || (r_ph == PH_WRITE)) begin
                        if (w_last) begin
                            r_l     <= '0;
                            r_r     <= '0;
                            r_c     <= '0;
                            r_state <= (r_state == S_COPY) ? S_COPY_END : S_NEXT;
                        end else if (r_c != w_cmax) begin
                            r_c <= r_c + 1'b1;
                        end else begin
                            r_c <= '0;
                            if (r_r != w_rmax) begin
                                r_r <= r_r + 1'b1;
                            end else begin
                                r_r <= '0;
                                r_l <= r_l + 1'b1;
                            end
                        end
                    end
                    if (r_state == S_FILT) begin
                        r_q_l <= w_nl;
                        case (r_ph)
                            PH_MINUS: begin
                                r_v  <= s_rdata;
                                r_fc <= w_fl;
                            end
                            PH_PLUS: begin
                                r_a  <= s_rdata;
                                r_fa <= w_fl;
                            end
                            PH_LAST: begin
                                r_b  <= s_rdata;
                                r_fb <= w_fl;
                            end
                            default: begin
                                r_fb <= r_fb;
                            end
                        endcase
                        r_ph <= (r_ph == PH_WRITE) ? PH_CENTER : r_ph + 3'd1;
                    end
                end
                S_COPY_END: begin
                    r_ph    <= PH_CENTER;
                    r_state <= S_FILT;
                end
                S_NEXT: begin
                    if (r_axis == AX_LAYER) begin
                        r_axis <= AX_COL;
                        if (r_pass == r_passes - 4'd1) begin
                            r_state <= S_DONE;
                        end else begin
                            r_pass  <= r_pass + 4'd1;
                            r_state <= S_AXIS;
                        end
                    end else begin
                        r_axis  <= r_axis + 2'd1;
                        r_state <= S_AXIS;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_value <= '0;
                        r_out_done  <= 1'b1;
                        r_pass      <= '0;
                        r_state     <= S_IDLE;
                    end else begin
                        r_out_valid <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_cfg_ready  = 1'b1;
    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_out_value;
    assign o_run_done   = r_out_done;
endmodule

FILE: src/sgdf_checker.sv
// port level checks of the grid damping filter and their binding
`include "assert_macros.svh"

module sgdf_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic [1:0]         i_func,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [31:0] o_read_value,
    input logic               o_run_done
);
    import sgdf_pkg::*;

    // run completion carries a zero value
    `SGDF_ASSERT(a_done_zero, i_clk, i_rst_n, o_out_valid && o_run_done |-> o_read_value == '0)
    // surface clearing holds off requests right after reset
    `SGDF_ASSERT(a_clear_busy, i_clk, i_rst_n, $past(!i_rst_n) |-> !o_in_ready)
    // an accepted run or read keeps the block busy in the next cycle
    `SGDF_ASSERT(a_busy_after, i_clk, i_rst_n,
        i_in_valid && o_in_ready && (i_func == FUNC_RUN || i_func == FUNC_RD_CELL)
        |=> !o_in_ready)
    // a waiting result holds
    `SGDF_ASSERT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_read_value) &&
        $stable(o_run_done))
endmodule

bind shapiro_grid_damping_filter sgdf_checker u_sgdf_checker (.*);
